FILE: design/twodo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-wheel odometry package
// Shared constants, types and helper functions for the odometry block.
// ----------------------------------------------------------------------------
package twodo_pkg;

	// CORDIC iteration count (valid range 12 to 32).
	localparam int CORDIC_STEPS = 24;

	// Serial arithmetic unit sizes.
	localparam int MUL_STEPS = 33;
	localparam int DIV_STEPS = 63;
	localparam int CNT_W     = 6;

	// Register reset values.
	localparam logic [31:0] DPC_RESET = 32'd1218103;
	localparam logic [22:0] TW_RESET  = 23'd786432;
	localparam logic [22:0] RO_RESET  = 23'd327680;
	localparam logic [22:0] BO_RESET  = 23'd393216;

	// Fixed-point constants.
	localparam logic signed [69:0] PI_WIDE     = 70'sd3373259426;
	localparam logic signed [32:0] PI_D        = 33'sd3373259426;
	localparam logic signed [32:0] SMALL_ANGLE = 33'sd16777216;
	localparam logic [31:0]        Q30_ONE     = 32'd1073741824;
	localparam logic [32:0]        TWO_OVER_PI = 33'd1367130551;
	localparam logic [32:0]        INV_GAIN    = 33'd652032874;
	localparam logic [32:0]        CHORD_DIV   = 33'd24;
	localparam logic signed [69:0] ROUND_HALF  = 70'sd536870912;
	localparam logic signed [69:0] MAX32       = 70'sd2147483647;
	localparam logic signed [69:0] MIN32       = -70'sd2147483648;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_DPC = 2'd0,
		CFG_TW  = 2'd1,
		CFG_RO  = 2'd2,
		CFG_BO  = 2'd3
	} twodo_cfg_idx_t;

	// Serial arithmetic operations.
	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} twodo_op_t;

	// Request to the serial multiplier/divider.
	typedef struct packed {
		logic        start;
		twodo_op_t   op;
		logic        neg;
		logic [62:0] a;
		logic [32:0] b;
	} twodo_arith_req_t;

	// Request to the CORDIC rotator.
	typedef struct packed {
		logic               start;
		logic signed [35:0] x0;
		logic signed [35:0] y0;
		logic [31:0]        ang;
	} twodo_rot_req_t;

	// Status of an iterative unit.
	typedef struct packed {
		logic busy;
		logic done;
	} twodo_unit_sts_t;

	// Arctangent of 2^-i as a binary angle.
	localparam logic [31:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// Magnitude of a signed value.
	function automatic logic [35:0] mag36(input logic signed [35:0] v);
		return v[35] ? 36'(-v) : 36'(v);
	endfunction

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
		if (v > MAX32) begin
			return 32'sh7FFFFFFF;
		end else if (v < MIN32) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// True when a wide signed value lies outside the signed 32-bit range.
	function automatic logic ovf32(input logic signed [69:0] v);
		return (v > MAX32) || (v < MIN32);
	endfunction

endpackage
`default_nettype wire

FILE: design/twodo_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Odometry channels
// Valid/ready channels for wheel samples and for pose results.
// ----------------------------------------------------------------------------
interface twodo_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_angle;
	logic signed [31:0] right_angle;
	logic signed [31:0] back_angle;

	modport source(output valid, output left_angle, output right_angle,
		output back_angle, input ready);
	modport sink(input valid, input left_angle, input right_angle,
		input back_angle, output ready);
endinterface

interface twodo_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_position;
	logic signed [31:0] y_position;
	logic [31:0]        heading;
	logic               saturated;

	modport source(output valid, output x_position, output y_position,
		output heading, output saturated, input ready);
	modport sink(input valid, input x_position, input y_position,
		input heading, input saturated, output ready);
endinterface
`default_nettype wire

FILE: design/twodo_arith.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial multiplier and divider
// Shift-add multiply and restoring divide on magnitudes, one bit per cycle,
// with the sign applied to the result.
// ----------------------------------------------------------------------------
module twodo_arith (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire twodo_pkg::twodo_arith_req_t req,
	output twodo_pkg::twodo_unit_sts_t       sts,
	output logic signed [69:0]               result
);

	twodo_pkg::twodo_op_t       op_q;
	logic                       neg_q;
	logic [35:0]                a_q;
	logic [35:0]                hi_q;
	logic [32:0]                lo_q;
	logic [32:0]                dvs_q;
	logic [62:0]                dvd_q;
	logic [32:0]                rem_q;
	logic [twodo_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [36:0]                sum;
	logic [34:0]                trial;
	logic [twodo_pkg::CNT_W-1:0] last;
	logic [69:0]                mag;

	// One partial product or one trial subtraction per cycle.
	assign sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 37'd0);
	assign trial = {1'b0, rem_q, dvd_q[62]} - {2'b00, dvs_q};
	assign last  = (op_q == twodo_pkg::OP_MUL) ?
		twodo_pkg::CNT_W'(twodo_pkg::MUL_STEPS - 1) :
		twodo_pkg::CNT_W'(twodo_pkg::DIV_STEPS - 1);

	// Signed result from the finished magnitude.
	assign mag    = (op_q == twodo_pkg::OP_MUL) ? {1'b0, hi_q, lo_q} : {7'd0, dvd_q};
	assign result = neg_q ? -$signed(mag) : $signed(mag);
	assign sts    = '{busy: busy_q, done: done_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand load and shift registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			neg_q <= req.neg;
			a_q   <= req.a[35:0];
			hi_q  <= '0;
			lo_q  <= req.b;
			dvs_q <= req.b;
			dvd_q <= req.a;
			rem_q <= '0;
		end else if (busy_q) begin
			if (op_q == twodo_pkg::OP_MUL) begin
				{hi_q, lo_q} <= {sum, lo_q[32:1]};
			end else begin
				if (!trial[34]) begin
					rem_q <= trial[32:0];
				end else begin
					rem_q <= {rem_q[31:0], dvd_q[62]};
				end
				dvd_q <= {dvd_q[61:0], ~trial[34]};
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/twodo_rotator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC rotator
// Rotates a vector by a binary angle, one iteration per cycle, after folding
// the angle into the right half plane. Gain is not compensated here.
// ----------------------------------------------------------------------------
module twodo_rotator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire twodo_pkg::twodo_rot_req_t req,
	output twodo_pkg::twodo_unit_sts_t     sts,
	output logic signed [35:0]             x,
	output logic signed [35:0]             y
);

	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	logic signed [32:0] z_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic               done_q;

	logic               flip;
	logic [31:0]        ang_fold;
	logic signed [35:0] xs;
	logic signed [35:0] ys;
	logic signed [32:0] at;

	// Angles in the second and third quadrant rotate the negated vector.
	assign flip     = (req.ang[31:30] == 2'b01) || (req.ang[31:30] == 2'b10);
	assign ang_fold = {req.ang[31] ^ flip, req.ang[30:0]};

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = $signed({1'b0, twodo_pkg::ATAN_TURNS[i_q]});

	assign x   = x_q;
	assign y   = y_q;
	assign sts = '{busy: busy_q, done: done_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(twodo_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Vector and residual angle.
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= flip ? -req.x0 : req.x0;
			y_q <= flip ? -req.y0 : req.y0;
			z_q <= 33'($signed(ang_fold));
		end else if (busy_q) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

endmodule
`default_nettype wire

FILE: design/three_wheel_odometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Three-wheel arc odometry
// Each accepted item runs 12 multiplies, 2 divides and two 24-iteration rotations
// on a turn, or one rotation on a near-straight step, on the serial units, and
// then the pose update. A new item is accepted only once the last one has
// reached the pose update, so items are handled one at a time.
// The next item is accepted while a finished result still waits.
// Reset clears the pose, last angles and handshake state and loads register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module three_wheel_odometry (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	twodo_sample_if.sink     sample,
	twodo_pose_if.source     pose
);

	typedef enum logic [4:0] {
		S_IDLE, S_DL, S_DR, S_DB, S_DIVD, S_PROD, S_SQ, S_DIV24, S_ROT1,
		S_GY1, S_DIVC, S_TWOS, S_LX1, S_LX2, S_LY1, S_LY2, S_ROT2, S_GX,
		S_GY, S_UPD
	} state_t;

	state_t state_q;
	state_t after;
	logic   go_q;
	logic   out_valid_q;
	logic   sat_q;

	logic [31:0]        dpc_q;
	logic [22:0]        tw_q;
	logic [22:0]        ro_q;
	logic [22:0]        bo_q;
	logic [31:0]        last_l_q;
	logic [31:0]        last_r_q;
	logic [31:0]        last_b_q;
	logic signed [31:0] pose_x_q;
	logic signed [31:0] pose_y_q;
	logic [31:0]        pose_h_q;

	logic signed [31:0] cnt_l_q;
	logic signed [31:0] cnt_r_q;
	logic signed [31:0] cnt_b_q;
	logic signed [31:0] dl_q;
	logic signed [31:0] dr_q;
	logic signed [31:0] db_q;
	logic signed [32:0] d_q;
	logic [31:0]        bam_q;
	logic [31:0]        half_q;
	logic [33:0]        sq_q;
	logic signed [31:0] chord_q;
	logic signed [35:0] sy_q;
	logic signed [35:0] twos_q;
	logic signed [35:0] t1_q;
	logic signed [35:0] lx_q;
	logic signed [35:0] ly_q;
	logic signed [35:0] gx_q;
	logic signed [35:0] gy_q;

	twodo_pkg::twodo_arith_req_t arq;
	twodo_pkg::twodo_unit_sts_t  arith_sts;
	twodo_pkg::twodo_rot_req_t   rrq;
	twodo_pkg::twodo_unit_sts_t  rot_sts;
	logic signed [69:0]          result;
	logic signed [35:0]          rot_x;
	logic signed [35:0]          rot_y;

	logic               op_state;
	logic               rot_state;
	logic               step_done;
	logic               near_zero;
	logic               load_out;
	logic signed [32:0] diff;
	logic [22:0]        tw_eff;
	logic [35:0]        mag_d;
	logic [35:0]        mag_chord;
	logic [35:0]        mag_diff;
	logic [35:0]        mag_sy;
	logic [35:0]        mag_db;
	logic [35:0]        mag_dr;
	logic signed [69:0] sh16;
	logic signed [69:0] sh30;
	logic signed [69:0] rnd;
	logic signed [69:0] sum_x;
	logic signed [69:0] sum_y;

	twodo_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (arq),
		.sts    (arith_sts),
		.result (result)
	);

	twodo_rotator u_rotator (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rrq),
		.sts    (rot_sts),
		.x      (rot_x),
		.y      (rot_y)
	);

	// Handshake and step status.
	assign sample.ready = (state_q == S_IDLE);
	assign pose.valid   = out_valid_q;
	assign pose.x_position = pose_x_q;
	assign pose.y_position = pose_y_q;
	assign pose.heading    = pose_h_q;
	assign pose.saturated  = sat_q;

	assign op_state  = (state_q != S_IDLE) && (state_q != S_UPD);
	assign rot_state = (state_q == S_ROT1) || (state_q == S_ROT2);
	assign step_done = rot_state ? rot_sts.done : arith_sts.done;
	assign load_out  = (state_q == S_UPD) && (!out_valid_q || pose.ready);

	// Shared operand preparation.
	assign diff      = 33'(dl_q) - 33'(dr_q);
	assign tw_eff    = (tw_q == 23'd0) ? 23'd1 : tw_q;
	assign mag_d     = twodo_pkg::mag36(36'(d_q));
	assign mag_chord = twodo_pkg::mag36(36'(chord_q));
	assign mag_diff  = twodo_pkg::mag36(36'(diff));
	assign mag_sy    = twodo_pkg::mag36(sy_q);
	assign mag_db    = twodo_pkg::mag36(36'(db_q));
	assign mag_dr    = twodo_pkg::mag36(36'(dr_q));
	assign near_zero = (d_q > -twodo_pkg::SMALL_ANGLE) && (d_q < twodo_pkg::SMALL_ANGLE);
	assign sh16      = result >>> 16;
	assign sh30      = result >>> 30;
	assign rnd       = (result + twodo_pkg::ROUND_HALF) >>> 30;
	assign sum_x     = 70'(pose_x_q) + 70'(gx_q);
	assign sum_y     = 70'(pose_y_q) + 70'(gy_q);

	// Operation issued by each step.
	always_comb begin
		arq       = '0;
		arq.op    = twodo_pkg::OP_MUL;
		arq.start = op_state && !rot_state && !go_q;
		unique case (state_q)
			S_DL: begin
				arq.a   = {27'd0, twodo_pkg::mag36(36'(cnt_l_q))};
				arq.b   = {1'b0, dpc_q};
				arq.neg = cnt_l_q[31];
			end
			S_DR: begin
				arq.a   = {27'd0, twodo_pkg::mag36(36'(cnt_r_q))};
				arq.b   = {1'b0, dpc_q};
				arq.neg = cnt_r_q[31];
			end
			S_DB: begin
				arq.a   = {27'd0, twodo_pkg::mag36(36'(cnt_b_q))};
				arq.b   = {1'b0, dpc_q};
				arq.neg = cnt_b_q[31];
			end
			S_DIVD: begin
				arq.op  = twodo_pkg::OP_DIV;
				arq.a   = {mag_diff[32:0], 30'd0};
				arq.b   = {10'd0, tw_eff};
				arq.neg = diff[32];
			end
			S_PROD: begin
				arq.a   = {27'd0, mag_d};
				arq.b   = twodo_pkg::TWO_OVER_PI;
				arq.neg = d_q[32];
			end
			S_SQ: begin
				arq.a = {27'd0, mag_d};
				arq.b = mag_d[32:0];
			end
			S_DIV24: begin
				arq.op = twodo_pkg::OP_DIV;
				arq.a  = {29'd0, sq_q};
				arq.b  = twodo_pkg::CHORD_DIV;
			end
			S_GY1, S_GY: begin
				arq.a   = {27'd0, twodo_pkg::mag36(rot_y)};
				arq.b   = twodo_pkg::INV_GAIN;
				arq.neg = rot_y[35];
			end
			S_DIVC: begin
				arq.op  = twodo_pkg::OP_DIV;
				arq.a   = {mag_sy[31:0], 31'd0};
				arq.b   = mag_d[32:0];
				arq.neg = sy_q[35] ^ d_q[32];
			end
			S_TWOS: begin
				arq.a   = {27'd0, mag_chord};
				arq.b   = mag_d[32:0];
				arq.neg = chord_q[31] ^ d_q[32];
			end
			S_LX1: begin
				arq.a   = {27'd0, mag_chord};
				arq.b   = mag_db[32:0];
				arq.neg = chord_q[31] ^ db_q[31];
			end
			S_LY1: begin
				arq.a   = {27'd0, mag_chord};
				arq.b   = mag_dr[32:0];
				arq.neg = chord_q[31] ^ dr_q[31];
			end
			S_LX2: begin
				arq.a   = {27'd0, twodo_pkg::mag36(twos_q)};
				arq.b   = {10'd0, bo_q};
				arq.neg = twos_q[35];
			end
			S_LY2: begin
				arq.a   = {27'd0, twodo_pkg::mag36(twos_q)};
				arq.b   = {10'd0, ro_q};
				arq.neg = twos_q[35];
			end
			S_GX: begin
				arq.a   = {27'd0, twodo_pkg::mag36(rot_x)};
				arq.b   = twodo_pkg::INV_GAIN;
				arq.neg = rot_x[35];
			end
			default: begin
				arq.start = 1'b0;
			end
		endcase
	end

	// Rotations: the half-angle sine, then the local step by minus mid heading.
	always_comb begin
		rrq       = '0;
		rrq.start = rot_state && !go_q;
		if (state_q == S_ROT1) begin
			rrq.x0  = 36'($signed({1'b0, twodo_pkg::Q30_ONE}));
			rrq.y0  = '0;
			rrq.ang = half_q;
		end else begin
			rrq.x0  = lx_q;
			rrq.y0  = ly_q;
			rrq.ang = 32'd0 - (pose_h_q + half_q);
		end
	end

	// Step order.
	always_comb begin
		unique case (state_q)
			S_DL:    after = S_DR;
			S_DR:    after = S_DB;
			S_DB:    after = S_DIVD;
			S_DIVD:  after = S_PROD;
			S_PROD:  after = near_zero ? S_SQ : S_ROT1;
			S_SQ:    after = S_DIV24;
			S_DIV24: after = S_TWOS;
			S_ROT1:  after = S_GY1;
			S_GY1:   after = S_DIVC;
			S_DIVC:  after = S_TWOS;
			S_TWOS:  after = S_LX1;
			S_LX1:   after = S_LX2;
			S_LX2:   after = S_LY1;
			S_LY1:   after = S_LY2;
			S_LY2:   after = S_ROT2;
			S_ROT2:  after = S_GX;
			S_GX:    after = S_GY;
			S_GY:    after = S_UPD;
			default: after = S_IDLE;
		endcase
	end

	// Sequencer, configuration registers, pose state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
			sat_q       <= 1'b0;
			dpc_q       <= twodo_pkg::DPC_RESET;
			tw_q        <= twodo_pkg::TW_RESET;
			ro_q        <= twodo_pkg::RO_RESET;
			bo_q        <= twodo_pkg::BO_RESET;
			last_l_q    <= '0;
			last_r_q    <= '0;
			last_b_q    <= '0;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			pose_h_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (twodo_pkg::twodo_cfg_idx_t'(cfg_index))
					twodo_pkg::CFG_DPC: dpc_q <= cfg_wdata;
					twodo_pkg::CFG_TW:  tw_q  <= cfg_wdata[22:0];
					twodo_pkg::CFG_RO:  ro_q  <= cfg_wdata[22:0];
					twodo_pkg::CFG_BO:  bo_q  <= cfg_wdata[22:0];
				endcase
			end
			// A new result takes the output slot; otherwise a taken one frees it.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
			if (arq.start || rrq.start) begin
				go_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						last_l_q <= sample.left_angle;
						last_r_q <= sample.right_angle;
						last_b_q <= sample.back_angle;
						state_q  <= S_DL;
					end
				end
				S_UPD: begin
					if (load_out) begin
						pose_x_q    <= twodo_pkg::sat32(sum_x);
						pose_y_q    <= twodo_pkg::sat32(sum_y);
						pose_h_q    <= pose_h_q + bam_q;
						sat_q       <= twodo_pkg::ovf32(sum_x) || twodo_pkg::ovf32(sum_y);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					if (go_q && step_done) begin
						go_q    <= 1'b0;
						state_q <= after;
					end
				end
			endcase
		end
	end

	// Datapath captures: wheel deltas on accept, and each step's result at its end.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && sample.valid) begin
			cnt_l_q <= sample.left_angle - $signed(last_l_q);
			cnt_r_q <= sample.right_angle - $signed(last_r_q);
			cnt_b_q <= sample.back_angle - $signed(last_b_q);
		end
		if (go_q && step_done) begin
			unique case (state_q)
				S_DL: dl_q <= twodo_pkg::sat32(sh16);
				S_DR: dr_q <= twodo_pkg::sat32(sh16);
				S_DB: db_q <= twodo_pkg::sat32(sh16);
				S_DIVD: begin
					if (result > twodo_pkg::PI_WIDE) begin
						d_q <= twodo_pkg::PI_D;
					end else if (result < -twodo_pkg::PI_WIDE) begin
						d_q <= -twodo_pkg::PI_D;
					end else begin
						d_q <= result[32:0];
					end
				end
				S_PROD: begin
					bam_q  <= result[62:31];
					half_q <= result[63:32];
				end
				S_SQ:    sq_q    <= result[63:30];
				S_DIV24: chord_q <= $signed(twodo_pkg::Q30_ONE) - result[31:0];
				S_GY1:   sy_q    <= rnd[35:0];
				S_DIVC:  chord_q <= result[31:0];
				S_TWOS:  twos_q  <= sh30[35:0];
				S_LX1:   t1_q    <= sh30[35:0];
				S_LX2:   lx_q    <= t1_q + sh30[35:0];
				S_LY1:   t1_q    <= sh30[35:0];
				S_LY2:   ly_q    <= t1_q + sh30[35:0];
				S_GX:    gx_q    <= rnd[35:0];
				S_GY:    gy_q    <= rnd[35:0];
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTH
	// A unit is never restarted in the middle of an operation.
	a_arith_idle: assert property (@(posedge clk) disable iff (!arst_n)
		arq.start |-> !arith_sts.busy)
		else $error("arith unit started while busy");

	a_rot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rrq.start |-> !rot_sts.busy)
		else $error("rotator started while busy");

	// The heading change is clamped to half a turn before it is used.
	a_d_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROD) |-> ((d_q <= twodo_pkg::PI_D) && (d_q >= -twodo_pkg::PI_D)))
		else $error("heading change outside clamp");

	// An accepted item starts with the left wheel distance.
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> (state_q == S_DL))
		else $error("accepted item did not start processing");
`endif

endmodule
`default_nettype wire
